/* design/cssm_pkg.sv */
`default_nettype none

package cssm_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);
  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic  end_of_text;
    logic  byte_valid;
    byte_t out_byte;
  } res_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STAR    = 3'd3,
    MODE_STRING  = 3'd4
  } mode_e;

  localparam byte_t ChLBrace    = 8'h7b;
  localparam byte_t ChRBrace    = 8'h7d;
  localparam byte_t ChColon     = 8'h3a;
  localparam byte_t ChSemi      = 8'h3b;
  localparam byte_t ChComma     = 8'h2c;
  localparam byte_t ChGreater   = 8'h3e;
  localparam byte_t ChSlash     = 8'h2f;
  localparam byte_t ChStar      = 8'h2a;
  localparam byte_t ChSQuote    = 8'h27;
  localparam byte_t ChDQuote    = 8'h22;
  localparam byte_t ChBackslash = 8'h5c;
  localparam byte_t ChSpace     = 8'h20;
  localparam byte_t ChTab       = 8'h09;
  localparam byte_t ChLf        = 8'h0a;
  localparam byte_t ChCr        = 8'h0d;

  function automatic logic is_space(input byte_t c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

  function automatic logic is_structural(input byte_t c);
    return (c == ChLBrace) || (c == ChRBrace) || (c == ChColon) ||
           (c == ChSemi) || (c == ChComma) || (c == ChGreater);
  endfunction

endpackage

`default_nettype wire

/* design/css_text_minifier.sv */
`default_nettype none

// Streaming CSS minifier. Source text enters one byte per beat on the slave
// side, with tlast on the final byte of a text. Comments outside strings are
// removed, strings pass unchanged, whitespace runs collapse to one space and
// spaces next to structural characters are dropped. Each accepted byte yields
// zero to three result beats; after the final byte a bare end marker beat
// (tuser low, tlast high) closes the text and all scanner state returns to
// its reset values. A byte is taken every cycle while the four-entry result
// queue holds at most one beat, so text that produces at most one result per
// byte streams at one byte per cycle while the sink stays ready. The sink
// drains one beat per cycle while ready, which paces multi-result bytes.
module css_text_minifier
  import cssm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [ByteW-1:0] s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic             s_axis_tlast_i,   // final_byte

  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [ByteW-1:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic                  m_axis_tuser_o,   // byte_valid
  output logic                  m_axis_tlast_o    // end_of_text
);

  mode_e mode_q, mode_d;
  logic  quote_q, quote_d;
  logic  space_q, space_d;
  logic  struct_q, struct_d;
  logic  emitted_q, emitted_d;
  logic  bslash_q, bslash_d;

  logic s_fire;
  logic m_fire;

  res_t               res [MaxRes];
  logic [ResCntW-1:0] res_n;

  res_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign s_axis_tready_o = (cnt_q <= QCntW'(QDepth - MaxRes));
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    byte_t c;
    byte_t qch;
    logic  do_normal;
    c         = s_axis_tdata_i;
    qch       = quote_q ? ChSQuote : ChDQuote;
    do_normal = 1'b0;
    mode_d    = mode_q;
    quote_d   = quote_q;
    space_d   = space_q;
    struct_d  = struct_q;
    emitted_d = emitted_q;
    bslash_d  = bslash_q;
    res_n     = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
    end

    if (s_fire) begin
      unique case (mode_q)
        MODE_SLASH: begin
          if (c == ChStar) begin
            mode_d = MODE_COMMENT;
          end else begin
            res[res_n] = '{end_of_text: 1'b0, byte_valid: 1'b1, out_byte: ChSlash};
            res_n      = res_n + ResCntW'(1);
            struct_d   = is_structural(ChSlash);
            emitted_d  = 1'b1;
            mode_d     = MODE_NORMAL;
            do_normal  = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == ChStar) begin
            mode_d = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (c == ChSlash) begin
            mode_d = MODE_NORMAL;
          end else if (c != ChStar) begin
            mode_d = MODE_COMMENT;
          end
        end
        MODE_STRING: begin
          res[res_n] = '{end_of_text: 1'b0, byte_valid: 1'b1, out_byte: c};
          res_n      = res_n + ResCntW'(1);
          struct_d   = is_structural(c);
          emitted_d  = 1'b1;
          if (c == qch && !bslash_q) begin
            mode_d = MODE_NORMAL;
          end
          bslash_d = (c == ChBackslash);
        end
        default: begin
          mode_d    = MODE_NORMAL;
          do_normal = 1'b1;
        end
      endcase

      if (do_normal) begin
        if (is_space(c)) begin
          if (emitted_d && !struct_d) begin
            space_d = 1'b1;
          end
        end else begin
          if (space_d) begin
            space_d = 1'b0;
            if (!is_structural(c)) begin
              res[res_n] = '{end_of_text: 1'b0, byte_valid: 1'b1, out_byte: ChSpace};
              res_n      = res_n + ResCntW'(1);
              struct_d   = 1'b0;
              emitted_d  = 1'b1;
            end
          end
          if (c == ChSlash) begin
            mode_d = MODE_SLASH;
          end else begin
            res[res_n] = '{end_of_text: 1'b0, byte_valid: 1'b1, out_byte: c};
            res_n      = res_n + ResCntW'(1);
            struct_d   = is_structural(c);
            emitted_d  = 1'b1;
            if (c == ChDQuote || c == ChSQuote) begin
              mode_d   = MODE_STRING;
              quote_d  = (c == ChSQuote);
              bslash_d = 1'b0;
            end
          end
        end
      end

      if (s_axis_tlast_i) begin
        if (mode_d == MODE_SLASH) begin
          res[res_n] = '{end_of_text: 1'b0, byte_valid: 1'b1, out_byte: ChSlash};
          res_n      = res_n + ResCntW'(1);
        end
        res[res_n] = '{end_of_text: 1'b1, byte_valid: 1'b0, out_byte: '0};
        res_n      = res_n + ResCntW'(1);
        mode_d     = MODE_NORMAL;
        quote_d    = 1'b0;
        space_d    = 1'b0;
        struct_d   = 1'b0;
        emitted_d  = 1'b0;
        bslash_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      quote_q   <= 1'b0;
      space_q   <= 1'b0;
      struct_q  <= 1'b0;
      emitted_q <= 1'b0;
      bslash_q  <= 1'b0;
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      quote_q   <= quote_d;
      space_q   <= space_d;
      struct_q  <= struct_d;
      emitted_q <= emitted_d;
      bslash_q  <= bslash_d;
      wr_q      <= wr_q + QPtrW'(res_n);
      rd_q      <= rd_q + QPtrW'(m_fire);
      cnt_q     <= cnt_q + QCntW'(res_n) - QCntW'(m_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (ResCntW'(i) < res_n) begin
        q_mem[wr_q + QPtrW'(i)] <= res[i];
      end
    end
  end

  assign m_axis_tdata_o = q_mem[rd_q].out_byte;
  assign m_axis_tuser_o = q_mem[rd_q].byte_valid;
  assign m_axis_tlast_o = q_mem[rd_q].end_of_text;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  import cssm_pkg::*;

  localparam int unsigned RandItems = 445;
  localparam int unsigned TailItems = 60;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    byte_t b;
    logic  fin;
    logic  hold;
  } src_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  byte_t      s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  byte_t      m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  src_item_t  pend_q[$];
  res_t       exp_q[$];
  logic       in_fire = 1'b0;
  int         src_gap = 0;
  int         sink_gap = 0;
  int         errors = 0;
  int         bytes_in = 0;
  int         texts_in = 0;
  int         beats_out = 0;
  int         cycles = 0;
  int         directed_n = 0;

  mode_e      scan_st = MODE_NORMAL;
  logic       sq_open = 1'b0;
  logic       ws_held = 1'b0;
  logic       after_punct = 1'b0;
  logic       started = 1'b0;
  logic       esc_prev = 1'b0;

  css_text_minifier uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic ws_char(input byte_t c);
    case (c)
      ChSpace, ChTab, ChLf, ChCr: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic punct_char(input byte_t c);
    case (c)
      ChLBrace, ChRBrace, ChColon, ChSemi, ChComma, ChGreater: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit_char(input byte_t b);
    exp_q.push_back('{end_of_text: 1'b0, byte_valid: 1'b1, out_byte: b});
    after_punct = punct_char(b);
    started = 1'b1;
  endtask

  task automatic plain_char(input byte_t c);
    if (ws_char(c)) begin
      if (started && !after_punct) ws_held = 1'b1;
    end else begin
      if (ws_held) begin
        ws_held = 1'b0;
        if (!punct_char(c)) emit_char(ChSpace);
      end
      if (c == ChSlash) begin
        scan_st = MODE_SLASH;
      end else begin
        emit_char(c);
        if (c == ChDQuote || c == ChSQuote) begin
          scan_st = MODE_STRING;
          sq_open = (c == ChSQuote);
          esc_prev = 1'b0;
        end
      end
    end
  endtask

  task automatic minify_byte(input byte_t c, input logic fin);
    case (scan_st)
      MODE_SLASH: begin
        if (c == ChStar) begin
          scan_st = MODE_COMMENT;
        end else begin
          emit_char(ChSlash);
          scan_st = MODE_NORMAL;
          plain_char(c);
        end
      end
      MODE_COMMENT: begin
        if (c == ChStar) scan_st = MODE_STAR;
      end
      MODE_STAR: begin
        if (c == ChSlash) scan_st = MODE_NORMAL;
        else if (c != ChStar) scan_st = MODE_COMMENT;
      end
      MODE_STRING: begin
        emit_char(c);
        if (c == (sq_open ? ChSQuote : ChDQuote) && !esc_prev) scan_st = MODE_NORMAL;
        esc_prev = (c == ChBackslash);
      end
      default: begin
        scan_st = MODE_NORMAL;
        plain_char(c);
      end
    endcase
    if (fin) begin
      if (scan_st == MODE_SLASH) emit_char(ChSlash);
      exp_q.push_back('{end_of_text: 1'b1, byte_valid: 1'b0, out_byte: '0});
      scan_st = MODE_NORMAL;
      sq_open = 1'b0;
      ws_held = 1'b0;
      after_punct = 1'b0;
      started = 1'b0;
      esc_prev = 1'b0;
    end
  endtask

  task automatic add_byte(input byte_t b, input logic fin, input logic hold);
    pend_q.push_back('{b: b, fin: fin, hold: hold});
  endtask

  task automatic add_text(input string s, input logic fin_end);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(byte_t'(s[i]), fin_end && (i == s.len() - 1), 1'b0);
    end
  endtask

  function automatic byte_t letter();
    return 8'h61 + byte_t'($urandom_range(0, 25));
  endfunction

  function automatic byte_t punct_pick();
    case ($urandom_range(0, 5))
      0: return ChLBrace;
      1: return ChRBrace;
      2: return ChColon;
      3: return ChSemi;
      4: return ChComma;
      default: return ChGreater;
    endcase
  endfunction

  function automatic byte_t ws_pick();
    case ($urandom_range(0, 3))
      0: return ChTab;
      1: return ChLf;
      2: return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  task automatic build_text(input int len, input logic hold_first);
    byte_t buf_q[$];
    byte_t q;
    int    n;
    while (buf_q.size() < len) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 4);
          repeat (n) buf_q.push_back(letter());
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) buf_q.push_back(ws_pick());
        end
        3: buf_q.push_back(punct_pick());
        4: begin
          buf_q.push_back(ChSlash);
          buf_q.push_back(ChStar);
          n = $urandom_range(0, 4);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: buf_q.push_back(ChStar);
              1: buf_q.push_back(ChSlash);
              2: buf_q.push_back(ws_pick());
              default: buf_q.push_back(letter());
            endcase
          end
          buf_q.push_back(ChStar);
          buf_q.push_back(ChSlash);
        end
        5: begin
          q = $urandom_range(0, 1) ? ChSQuote : ChDQuote;
          buf_q.push_back(q);
          n = $urandom_range(0, 4);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0: begin
                buf_q.push_back(ChBackslash);
                buf_q.push_back($urandom_range(0, 1) ? q : letter());
              end
              1: buf_q.push_back(q == ChSQuote ? ChDQuote : ChSQuote);
              2: buf_q.push_back($urandom_range(0, 1) ? ChSlash : ChStar);
              default: buf_q.push_back(letter());
            endcase
          end
          if ($urandom_range(0, 7) != 0) buf_q.push_back(q);
        end
        6: buf_q.push_back(ChSlash);
        7: buf_q.push_back(ChStar);
        default: buf_q.push_back(byte_t'($urandom_range(0, 255)));
      endcase
    end
    foreach (buf_q[i]) begin
      add_byte(buf_q[i], i == buf_q.size() - 1, hold_first && (i == 0));
    end
  endtask

  always @(negedge clk) begin : drive
    logic nxt_valid;
    src_item_t it;
    if (rst_n) begin
      if (!s_tvalid || in_fire) begin
        nxt_valid = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pend_q.size() > 0 && !(pend_q[0].hold && exp_q.size() != 0)) begin
          if (pend_q.size() > TailItems && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 2);
          end else begin
            it = pend_q.pop_front();
            s_tdata <= it.b;
            s_tlast <= it.fin;
            nxt_valid = 1'b1;
          end
        end
        s_tvalid <= nxt_valid;
      end
    end
  end

  always @(negedge clk) begin : sink
    if (rst_n) begin
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (pend_q.size() > TailItems && $urandom_range(0, 4) == 0) begin
        sink_gap = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        minify_byte(s_tdata, s_tlast);
        bytes_in++;
        if (s_tlast) texts_in++;
      end
      if (m_tvalid && m_tready) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected beat data=%02h user=%b last=%b",
                   $time, m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          want = exp_q.pop_front();
          beats_out++;
          if (m_tdata !== want.out_byte || m_tuser !== want.byte_valid ||
              m_tlast !== want.end_of_text) begin
            $display("%0t: mismatch expected data=%02h user=%b last=%b got data=%02h user=%b last=%b",
                     $time, want.out_byte, want.byte_valid, want.end_of_text,
                     m_tdata, m_tuser, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d items pending and %0d beats expected",
               $time, pend_q.size(), exp_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : main
    int ntext;
    ntext = 0;
    add_text("x /**/ y", 1'b1);
    add_text("'\\''>", 1'b1);
    add_text("a/", 1'b1);
    add_byte(8'hff, 1'b0, 1'b0);
    add_text("/*", 1'b1);
    add_byte(ChDQuote, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_text("\r{\ta\n}", 1'b1);
    directed_n = pend_q.size();
    while (pend_q.size() < directed_n + RandItems) begin
      build_text($urandom_range(1, 24), (ntext % 8) == 3);
      ntext++;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pend_q.size() == 0 && !s_tvalid);
    wait (exp_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Fed %0d bytes (%0d directed) in %0d texts with comments, strings and noise.",
             bytes_in, directed_n, texts_in);
    $display("Checked %0d result beats under random stalls; %0d mismatches.",
             beats_out, errors);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
